[design/slcfc_pkg.sv]
// ----------------------------------------------------------------------------
// slcfc_pkg
// shared phase, status and configuration codes and reset values for the start/length/checksum frame checker
// ----------------------------------------------------------------------------
package slcfc_pkg;

    typedef logic [2:0] phase_t;
    typedef logic [1:0] status_t;

    // frame phases
    localparam phase_t PH_HUNT   = 3'd0;
    localparam phase_t PH_LEN_HI = 3'd1;
    localparam phase_t PH_LEN_LO = 3'd2;
    localparam phase_t PH_BODY   = 3'd3;
    localparam phase_t PH_CSUM   = 3'd4;
    localparam phase_t PH_END    = 3'd5;

    // frame status codes
    localparam status_t ST_GOOD    = 2'd0;
    localparam status_t ST_BAD_END = 2'd1;
    localparam status_t ST_CSUM    = 2'd2;
    localparam status_t ST_LENGTH  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  START_MARKER_RST = 8'h68;
    localparam logic [7:0]  END_MARKER_RST   = 8'h16;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'hFFFF;

    // smallest frame: start, two length bytes, checksum, end
    localparam logic [15:0] MIN_FRAME_LEN = 16'd5;

endpackage

[design/start_length_checksum_frame_checker.sv]
// ----------------------------------------------------------------------------
// start_length_checksum_frame_checker
// byte stream deframer with start marker, length header and byte-sum checksum
// ----------------------------------------------------------------------------
// Takes one received byte per beat and gives one marked beat back for each,
// registered, at one byte per clock while out_stall is low. A frame is the
// start marker, a two-byte big-endian total length (counting every byte of
// the frame), the body, a checksum byte and the end marker; the checksum is
// the byte sum modulo 256 from the start marker up to the byte before the
// checksum. Bytes seen while hunting come out with hunt_drop set. A frame is
// closed with frame_done on its end byte (status good, bad end, or checksum
// mismatch; bad end wins if both) or on the second length byte if the length
// is below five or above the configured max length. After closing, hunting starts
// with the next byte. The per-byte update is one pass of the phase state
// machine feeding a single result register; that result register decouples
// the two sides, so a new byte is taken whenever the result register is
// empty or being emptied in the same cycle. Configuration writes take effect
// at the next edge and may be made at any time.
// ----------------------------------------------------------------------------
module start_length_checksum_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // received byte beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    // marked byte beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_echo,
    output logic        inside_frame,
    output logic        hunt_drop,
    output logic        frame_done,
    output logic [1:0]  frame_status,
    output logic [15:0] frame_total_length
);

    // configuration registers
    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [15:0] max_length_reg;

    // frame state
    slcfc_pkg::phase_t phase_reg, phase_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  csum_reg, csum_next;

    // result register
    logic        out_valid_reg;
    logic [7:0]  echo_reg;
    logic        inside_reg, inside_next;
    logic        drop_reg, drop_next;
    logic        done_reg, done_next;
    slcfc_pkg::status_t status_reg, status_next;
    logic [15:0] total_reg, total_next;

    logic        in_accept;
    logic [15:0] len_full;
    logic [15:0] seen_inc;
    logic [16:0] body_end_cmp;

    // result register frees up in the same cycle it is taken
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // full length once the low byte is here
    assign len_full     = {decl_len_reg[15:8], rx_byte};
    assign seen_inc     = seen_reg + 16'd1;
    // body ends when two trailer bytes are left
    assign body_end_cmp = {1'b0, seen_inc} + 17'd2;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= slcfc_pkg::START_MARKER_RST;
            end_marker_reg   <= slcfc_pkg::END_MARKER_RST;
            max_length_reg   <= slcfc_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                slcfc_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data[7:0];
                slcfc_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data[7:0];
                slcfc_pkg::CFG_MAX_LENGTH:   max_length_reg   <= cfg_data;
                default:                     ; // unused index ignored
            endcase
        end
    end

    // ---- per-byte update ----
    always_comb
    begin
        phase_next    = phase_reg;
        decl_len_next = decl_len_reg;
        seen_next     = seen_reg;
        sum_next      = sum_reg;
        csum_next     = csum_reg;
        inside_next   = 1'b1;
        drop_next     = 1'b0;
        done_next     = 1'b0;
        status_next   = slcfc_pkg::ST_GOOD;
        total_next    = decl_len_reg;

        case (phase_reg)
            slcfc_pkg::PH_LEN_HI:
            begin
                decl_len_next = {rx_byte, 8'h00};
                sum_next      = sum_reg + rx_byte;
                seen_next     = 16'd2;
                phase_next    = slcfc_pkg::PH_LEN_LO;
                total_next    = 16'd0;
            end
            slcfc_pkg::PH_LEN_LO:
            begin
                decl_len_next = len_full;
                sum_next      = sum_reg + rx_byte;
                seen_next     = 16'd3;
                total_next    = len_full;
                if (len_full < slcfc_pkg::MIN_FRAME_LEN || len_full > max_length_reg)
                begin
                    // length out of range: close early and hunt again
                    done_next     = 1'b1;
                    status_next   = slcfc_pkg::ST_LENGTH;
                    phase_next    = slcfc_pkg::PH_HUNT;
                    decl_len_next = 16'd0;
                    seen_next     = 16'd0;
                    sum_next      = 8'd0;
                    csum_next     = 8'd0;
                end
                else if (len_full == slcfc_pkg::MIN_FRAME_LEN)
                begin
                    phase_next = slcfc_pkg::PH_CSUM;
                end
                else
                begin
                    phase_next = slcfc_pkg::PH_BODY;
                end
            end
            slcfc_pkg::PH_BODY:
            begin
                sum_next  = sum_reg + rx_byte;
                seen_next = seen_inc;
                if (body_end_cmp >= {1'b0, decl_len_reg})
                begin
                    phase_next = slcfc_pkg::PH_CSUM;
                end
            end
            slcfc_pkg::PH_CSUM:
            begin
                csum_next  = rx_byte;
                seen_next  = seen_inc;
                phase_next = slcfc_pkg::PH_END;
            end
            slcfc_pkg::PH_END:
            begin
                done_next = 1'b1;
                if (rx_byte != end_marker_reg)
                begin
                    status_next = slcfc_pkg::ST_BAD_END;
                end
                else if (csum_reg != sum_reg)
                begin
                    status_next = slcfc_pkg::ST_CSUM;
                end
                else
                begin
                    status_next = slcfc_pkg::ST_GOOD;
                end
                phase_next    = slcfc_pkg::PH_HUNT;
                decl_len_next = 16'd0;
                seen_next     = 16'd0;
                sum_next      = 8'd0;
                csum_next     = 8'd0;
            end
            default:
            begin
                // hunting, also covers unused phase codes
                total_next    = 16'd0;
                decl_len_next = 16'd0;
                csum_next     = 8'd0;
                if (rx_byte == start_marker_reg)
                begin
                    sum_next   = rx_byte;
                    seen_next  = 16'd1;
                    phase_next = slcfc_pkg::PH_LEN_HI;
                end
                else
                begin
                    inside_next = 1'b0;
                    drop_next   = 1'b1;
                    sum_next    = 8'd0;
                    seen_next   = 16'd0;
                    phase_next  = slcfc_pkg::PH_HUNT;
                end
            end
        endcase
    end

    // ---- frame state registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= slcfc_pkg::PH_HUNT;
            decl_len_reg <= 16'd0;
            seen_reg     <= 16'd0;
            sum_reg      <= 8'd0;
            csum_reg     <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            decl_len_reg <= decl_len_next;
            seen_reg     <= seen_next;
            sum_reg      <= sum_next;
            csum_reg     <= csum_next;
        end
    end

    // ---- result register: valid flag ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ---- result register: payload ----
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            echo_reg   <= rx_byte;
            inside_reg <= inside_next;
            drop_reg   <= drop_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            total_reg  <= total_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign byte_echo          = echo_reg;
    assign inside_frame       = inside_reg;
    assign hunt_drop          = drop_reg;
    assign frame_done         = done_reg;
    assign frame_status       = status_reg;
    assign frame_total_length = total_reg;

    // ---- assertions ----

    // a non-good status only ever comes with a closed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != slcfc_pkg::ST_GOOD) |-> done_reg)
    else $error("frame status set without frame_done");

    // the end byte always sends the checker back to hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == slcfc_pkg::PH_END) |=> phase_reg == slcfc_pkg::PH_HUNT)
    else $error("no return to hunting after end byte");

    // input is only held off while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
    else $error("input stalled with empty result register");

    // inside a frame the byte count is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != slcfc_pkg::PH_HUNT) |-> (seen_reg != 16'd0))
    else $error("frame in progress with zero byte count");

    // a closed frame is never also a dropped byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && done_next) |=> (out_valid_reg && !drop_reg))
    else $error("closing beat marked as dropped");

endmodule
